// ===== rtl/trcc_pkg.sv =====
`default_nettype none

package trcc_pkg;

  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 12;
  localparam int SPEED_W    = 10;
  localparam int MODE_W     = 2;
  localparam int TRIP_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = TIME_W + SPEED_W;

  typedef struct packed {
    logic [TIME_W-1:0]  time_now;
    logic [LEVEL_W-1:0] sensor_level;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] motor_speed;
    logic [MODE_W-1:0]  mode;
    logic [TRIP_W-1:0]  trip_count;
  } out_t;

  localparam logic [MODE_W-1:0] MODE_START = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_RAMP  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_COOL  = MODE_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_THRESHOLD    = CFG_IDX_W'(0),
    REG_RELEASE_THRESHOLD  = CFG_IDX_W'(1),
    REG_RAMP_TICKS         = CFG_IDX_W'(2),
    REG_PLATEAU_TICKS      = CFG_IDX_W'(3),
    REG_BREAK_OFFSET_TICKS = CFG_IDX_W'(4),
    REG_SPEED_MIN          = CFG_IDX_W'(5),
    REG_SPEED_MAX          = CFG_IDX_W'(6),
    REG_COOLDOWN_MIN_TICKS = CFG_IDX_W'(7)
  } cfg_reg_t;

  localparam logic [LEVEL_W-1:0] RST_UPPER_THRESHOLD    = LEVEL_W'(3000);
  localparam logic [LEVEL_W-1:0] RST_RELEASE_THRESHOLD  = LEVEL_W'(1500);
  localparam logic [TIME_W-1:0]  RST_RAMP_TICKS         = TIME_W'(10000);
  localparam logic [TIME_W-1:0]  RST_PLATEAU_TICKS      = TIME_W'(5000);
  localparam logic [TIME_W-1:0]  RST_BREAK_OFFSET_TICKS = TIME_W'(5000);
  localparam logic [SPEED_W-1:0] RST_SPEED_MIN          = SPEED_W'(100);
  localparam logic [SPEED_W-1:0] RST_SPEED_MAX          = SPEED_W'(1023);
  localparam logic [TIME_W-1:0]  RST_COOLDOWN_MIN_TICKS = TIME_W'(10000);

endpackage

`default_nettype wire

// ===== rtl/threshold_ramp_cooldown_controller.sv =====
//  channel  | direction | handshake              | payload
//  in       | input     | in_valid / in_ready    | in_data   (time_now, sensor_level)
//  out      | output    | out_valid / out_ready  | out_data  (motor_speed, mode, trip_count)
//  cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  a dividing ramp word passes evaluate, check, multiply, ten restoring-division
//  steps in the divider, quotient take-up and output load; a capped ramp word
//  passes evaluate, check and output load, others evaluate and output load; in_ready
//  is high only when idle; the finished result sits in an output register; a stalled
//  out_ready holds the sequencer in its emit step until the register frees
//  synchronous active-high reset restores register defaults and the controller state
`default_nettype none

module threshold_ramp_cooldown_controller (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire trcc_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output trcc_pkg::out_t                          out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [trcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [trcc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TW = trcc_pkg::TIME_W;
  localparam int LW = trcc_pkg::LEVEL_W;
  localparam int SW = trcc_pkg::SPEED_W;
  localparam int MW = trcc_pkg::MODE_W;
  localparam int CW = trcc_pkg::TRIP_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_CHK  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [LW-1:0] upper_threshold, release_threshold;
  logic [TW-1:0] ramp_ticks, plateau_ticks, break_offset_ticks, cooldown_min_ticks;
  logic [SW-1:0] speed_min, speed_max;

  logic [MW-1:0] mode_reg;
  logic [TW-1:0] ramp_start, cooldown_start;
  logic [CW-1:0] trip_counter;
  logic [SW-1:0] speed_reg;

  logic [TW-1:0] now;
  logic [LW-1:0] level;
  logic [TW-1:0] elapsed;

  logic [TW-1:0]              elapsed_raw, cool_elapsed;
  logic [TW:0]                ramp_limit;
  logic                       past_plateau;
  logic                       go_max;
  logic [SW-1:0]              span;
  logic [trcc_pkg::PROD_W-1:0] product;
  logic                       div_start, div_done;
  logic [SW-1:0]              div_quot;
  logic                       out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign elapsed_raw  = now - ramp_start;
  assign cool_elapsed = now - cooldown_start;
  assign ramp_limit   = {1'b0, ramp_ticks} + {1'b0, plateau_ticks};
  assign past_plateau = {1'b0, elapsed_raw} > ramp_limit;
  assign go_max       = (ramp_ticks == '0) || (speed_max <= speed_min) ||
                        (elapsed >= ramp_ticks);
  assign span         = speed_max - speed_min;
  assign product      = {{SW{1'b0}}, elapsed} * {{TW{1'b0}}, span};
  assign div_start    = (state == S_MUL);

  trcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (ramp_ticks),
    .done     (div_done),
    .quotient (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_threshold    <= trcc_pkg::RST_UPPER_THRESHOLD;
      release_threshold  <= trcc_pkg::RST_RELEASE_THRESHOLD;
      ramp_ticks         <= trcc_pkg::RST_RAMP_TICKS;
      plateau_ticks      <= trcc_pkg::RST_PLATEAU_TICKS;
      break_offset_ticks <= trcc_pkg::RST_BREAK_OFFSET_TICKS;
      speed_min          <= trcc_pkg::RST_SPEED_MIN;
      speed_max          <= trcc_pkg::RST_SPEED_MAX;
      cooldown_min_ticks <= trcc_pkg::RST_COOLDOWN_MIN_TICKS;
    end else if (cfg_valid) begin
      unique case (trcc_pkg::cfg_reg_t'(cfg_index))
        trcc_pkg::REG_UPPER_THRESHOLD:    upper_threshold    <= cfg_data[LW-1:0];
        trcc_pkg::REG_RELEASE_THRESHOLD:  release_threshold  <= cfg_data[LW-1:0];
        trcc_pkg::REG_RAMP_TICKS:         ramp_ticks         <= cfg_data[TW-1:0];
        trcc_pkg::REG_PLATEAU_TICKS:      plateau_ticks      <= cfg_data[TW-1:0];
        trcc_pkg::REG_BREAK_OFFSET_TICKS: break_offset_ticks <= cfg_data[TW-1:0];
        trcc_pkg::REG_SPEED_MIN:          speed_min          <= cfg_data[SW-1:0];
        trcc_pkg::REG_SPEED_MAX:          speed_max          <= cfg_data[SW-1:0];
        trcc_pkg::REG_COOLDOWN_MIN_TICKS: cooldown_min_ticks <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        if (mode_reg == trcc_pkg::MODE_RAMP && level < upper_threshold) begin
          state_next = S_CHK;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_CHK:  state_next = go_max ? S_EMIT : S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      now   <= in_data.time_now;
      level <= in_data.sensor_level;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= trcc_pkg::MODE_START;
      ramp_start     <= '0;
      cooldown_start <= '0;
      trip_counter   <= '0;
      speed_reg      <= '0;
    end else begin
      unique case (state)
        S_EVAL: begin
          case (mode_reg)
            trcc_pkg::MODE_RAMP: begin
              if (level < upper_threshold) begin
                if (past_plateau) begin
                  ramp_start <= now - break_offset_ticks;
                end
              end else begin
                speed_reg      <= '0;
                mode_reg       <= trcc_pkg::MODE_COOL;
                cooldown_start <= now;
                if (trip_counter != '1) begin
                  trip_counter <= trip_counter + CW'(1);
                end
              end
            end
            trcc_pkg::MODE_COOL: begin
              if (cool_elapsed >= cooldown_min_ticks && level < release_threshold) begin
                ramp_start <= now;
                mode_reg   <= trcc_pkg::MODE_RAMP;
              end
            end
            default: begin
              ramp_start <= now;
              mode_reg   <= trcc_pkg::MODE_RAMP;
            end
          endcase
        end
        S_CHK: if (go_max) speed_reg <= speed_max;
        S_DIV: if (div_done) speed_reg <= speed_min + div_quot;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      elapsed <= past_plateau ? break_offset_ticks : elapsed_raw;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_data.motor_speed <= speed_reg;
      out_data.mode        <= mode_reg;
      out_data.trip_count  <= trip_counter;
    end
  end

`ifndef SYNTHESIS
  a_cool_zero_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode == trcc_pkg::MODE_COOL |-> out_data.motor_speed == '0)
    else $error("motor speed not zero in cooldown");

  a_trip_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> trip_counter >= $past(trip_counter))
    else $error("trip counter went backwards");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its step");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EVAL)
    else $error("accepted word not evaluated");
`endif

endmodule

`default_nettype wire

// ===== rtl/trcc_div.sv =====
`default_nettype none

module trcc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [trcc_pkg::PROD_W-1:0]   dividend,
  input  wire logic [trcc_pkg::TIME_W-1:0]   divisor,
  output logic                               done,
  output logic [trcc_pkg::SPEED_W-1:0]       quotient
);

  localparam int QW    = trcc_pkg::SPEED_W;
  localparam int TW    = trcc_pkg::TIME_W;
  localparam int CNT_W = $clog2(QW);

  // remainder stays below divisor, so only QW quotient bits are produced
  logic [TW-1:0]    rem;
  logic [QW-1:0]    low;
  logic [TW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [TW:0]   partial;
  logic [TW+1:0] diff;
  logic          borrow;

  assign partial  = {rem, low[QW-1]};
  assign diff     = {1'b0, partial} - {2'b00, dvs};
  assign borrow   = diff[TW+1];
  assign quotient = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[trcc_pkg::PROD_W-1:QW];
      low <= dividend[QW-1:0];
      dvs <= divisor;
    end else if (busy) begin
      if (!borrow) begin
        rem <= diff[TW-1:0];
      end else begin
        rem <= partial[TW-1:0];
      end
      low <= {low[QW-2:0], ~borrow};
    end
  end

endmodule

`default_nettype wire
